/* rtl/core/lbsm_pkg.sv */
// ----------------------------------------------------------------------------
// lbsm_pkg: shared definitions for the LRU buffer slot manager
// Sizes, command and status codes, control states, item types and the probe and commit structs.
// ----------------------------------------------------------------------------
package lbsm_pkg;

  // Sizing
  localparam int SLOTS         = 32;
  localparam int DISK_BLOCKS_N = 8192;
  localparam int AGE_BITS      = 16;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TAG_W = (DISK_BLOCKS_N > 1) ? $clog2(DISK_BLOCKS_N) : 1;

  // Fixed field widths of the item ports
  localparam int CMD_W  = 2;
  localparam int BLK_W  = 16;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 5;
  localparam int WB_W   = 13;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIRTY  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

  // Control states of the top level
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [BLK_W-1:0] block_num;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              writeback_valid;
    logic [WB_W-1:0]   writeback_block;
  } out_item_t;

  // Request that walks down the cell row, gathering scan results
  typedef struct packed {
    logic                active;
    logic [CMD_W-1:0]    cmd;
    logic [TAG_W-1:0]    tag;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                old_found;
    logic [IDX_W-1:0]    old_idx;
    logic [AGE_BITS-1:0] old_age;
    logic                old_dirty;
    logic [TAG_W-1:0]    old_tag;
    logic                hit_found;
    logic [IDX_W-1:0]    hit_idx;
  } probe_t;

  // Update broadcast to the cells once the scan has finished
  typedef struct packed {
    logic             valid;
    logic             alloc;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
  } commit_t;

endpackage

/* rtl/core/lbsm_cell.sv */
// ----------------------------------------------------------------------------
// lbsm_cell: one buffer slot of the manager
// Holds valid, dirty, age and tag of a slot. Folds its own state into the
// passing probe (free, oldest, match), ages itself on allocate, and applies
// the commit broadcast addressed to it.
// ----------------------------------------------------------------------------
module lbsm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lbsm_pkg::IDX_W-1:0] cell_idx,
  input  lbsm_pkg::probe_t           probe_i,
  output lbsm_pkg::probe_t           probe_o,
  input  lbsm_pkg::commit_t          commit_i
);

  logic                          valid_r;
  logic                          dirty_r;
  logic [lbsm_pkg::AGE_BITS-1:0] age_r;
  logic [lbsm_pkg::TAG_W-1:0]    tag_r;
  lbsm_pkg::probe_t              probe_r;
  lbsm_pkg::probe_t              probe_nxt;
  logic [lbsm_pkg::AGE_BITS-1:0] aged;
  logic                          do_age;
  logic                          commit_hit;

  // Saturating age as seen by this allocate
  assign aged = (valid_r && (age_r != lbsm_pkg::AGE_MAX)) ? (age_r + 1'b1) : age_r;
  assign do_age     = probe_i.active && (probe_i.cmd == lbsm_pkg::CMD_ALLOC) && valid_r;
  assign commit_hit = commit_i.valid && (commit_i.idx == cell_idx);

  // Merge this slot into the scan results
  always_comb begin
    probe_nxt = probe_i;
    if (!valid_r && !probe_i.free_found) begin
      probe_nxt.free_found = 1'b1;
      probe_nxt.free_idx   = cell_idx;
    end
    if (valid_r && (!probe_i.old_found || (aged > probe_i.old_age))) begin
      probe_nxt.old_found = 1'b1;
      probe_nxt.old_idx   = cell_idx;
      probe_nxt.old_age   = aged;
      probe_nxt.old_dirty = dirty_r;
      probe_nxt.old_tag   = tag_r;
    end
    if (valid_r && (tag_r == probe_i.tag) && !probe_i.hit_found) begin
      probe_nxt.hit_found = 1'b1;
      probe_nxt.hit_idx   = cell_idx;
    end
  end

  // Probe stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_o = probe_r;

  // Slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      age_r   <= '0;
    end else if (commit_hit) begin
      if (commit_i.alloc) begin
        valid_r <= 1'b1;
        dirty_r <= 1'b0;
        age_r   <= '0;
      end else begin
        dirty_r <= 1'b1;
      end
    end else if (do_age) begin
      age_r <= aged;
    end
  end

  // Tag, only meaningful while valid
  always_ff @(posedge clk) begin
    if (commit_hit && commit_i.alloc) begin
      tag_r <= commit_i.tag;
    end
  end

endmodule

/* rtl/core/lru_buffer_slot_manager_unit.sv */
// ----------------------------------------------------------------------------
// lru_buffer_slot_manager_unit: LRU slot manager of a disk-block buffer pool
// Allocates, looks up and marks dirty the slots of a SLOTS-entry pool.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes a command and a block
//   number. Output channel (out_valid / out_stall / out_item) returns one
//   result item per input item, in order.
//   A request is carried down a row of SLOTS cells, one cell per cycle; each
//   cell ages itself on an allocate and merges its free / oldest / tag-match
//   state into the request. At the end of the row the result is formed and the
//   chosen slot is updated in one broadcast.
//   An accepted request is registered at the head of the row, passes every
//   cell's probe register, then the result and output registers; an
//   out-of-bound block number skips the row. Throughput: one item at a time;
//   the next is taken the cycle after its result moves to the output register.
//   in_stall is high while an item is in flight. A result waiting behind a
//   stalled output holds in the output register while the next item runs.
//   Reset (rst_n low, synchronous) frees all slots and empties the outputs.
// ----------------------------------------------------------------------------
module lru_buffer_slot_manager_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lbsm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lbsm_pkg::out_item_t out_item
);

  lbsm_pkg::state_t    state_r;
  lbsm_pkg::state_t    state_nxt;
  lbsm_pkg::probe_t    probe0_r;
  lbsm_pkg::probe_t    probe0_nxt;
  lbsm_pkg::probe_t    probe_w [0:lbsm_pkg::SLOTS];
  lbsm_pkg::probe_t    last;
  lbsm_pkg::commit_t   commit;
  lbsm_pkg::out_item_t res_r;
  lbsm_pkg::out_item_t res_nxt;
  lbsm_pkg::out_item_t out_r;
  lbsm_pkg::out_item_t out_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                accept;
  logic                oob;
  logic                load_out;
  logic [lbsm_pkg::BLK_W:0]   blk_ext;
  logic [lbsm_pkg::IDX_W-1:0] pick;

  assign accept  = in_valid && !in_stall;
  assign blk_ext = {1'b0, in_item.block_num};
  assign oob     = in_item.block_num[lbsm_pkg::BLK_W-1] ||
                   (blk_ext >= (lbsm_pkg::BLK_W+1)'(lbsm_pkg::DISK_BLOCKS_N));
  assign last    = probe_w[lbsm_pkg::SLOTS];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbsm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = oob ? lbsm_pkg::S_DONE : lbsm_pkg::S_SCAN;
        end
      end
      lbsm_pkg::S_SCAN: begin
        if (last.active) begin
          state_nxt = lbsm_pkg::S_DONE;
        end
      end
      lbsm_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = lbsm_pkg::S_IDLE;
        end
      end
      default: state_nxt = lbsm_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      lbsm_pkg::S_IDLE: in_stall = 1'b0;
      lbsm_pkg::S_SCAN: in_stall = 1'b1;
      lbsm_pkg::S_DONE: load_out = !out_valid_r || !out_stall;
      default:          in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbsm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request injected at the head of the cell row
  always_comb begin
    probe0_nxt        = '0;
    probe0_nxt.active = accept && !oob;
    probe0_nxt.cmd    = in_item.command;
    probe0_nxt.tag    = in_item.block_num[lbsm_pkg::TAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe0_r <= '0;
    end else begin
      probe0_r <= probe0_nxt;
    end
  end

  assign probe_w[0] = probe0_r;

  // Cell row
  for (genvar i = 0; i < lbsm_pkg::SLOTS; i++) begin : g_cell
    lbsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lbsm_pkg::IDX_W'(i)),
      .probe_i  (probe_w[i]),
      .probe_o  (probe_w[i+1]),
      .commit_i (commit)
    );
  end

  // Result and slot update at the end of the row
  assign pick = last.free_found ? last.free_idx : last.old_idx;

  always_comb begin
    res_nxt      = res_r;
    commit       = '0;
    commit.tag   = last.tag;
    if (accept && oob) begin
      res_nxt        = '0;
      res_nxt.status = lbsm_pkg::STAT_OOB;
    end else if (last.active) begin
      res_nxt = '0;
      if (last.cmd == lbsm_pkg::CMD_ALLOC) begin
        res_nxt.status = lbsm_pkg::STAT_OK;
        res_nxt.slot   = lbsm_pkg::SLOT_W'(pick);
        if (!last.free_found && last.old_dirty) begin
          res_nxt.writeback_valid = 1'b1;
          res_nxt.writeback_block = lbsm_pkg::WB_W'(last.old_tag);
        end
        commit.valid = 1'b1;
        commit.alloc = 1'b1;
        commit.idx   = pick;
      end else if (last.hit_found) begin
        res_nxt.status = lbsm_pkg::STAT_OK;
        res_nxt.slot   = lbsm_pkg::SLOT_W'(last.hit_idx);
        commit.valid   = (last.cmd == lbsm_pkg::CMD_DIRTY);
        commit.idx     = last.hit_idx;
      end else begin
        res_nxt.status = lbsm_pkg::STAT_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* rtl/core/lbsm_checker.sv */
// ----------------------------------------------------------------------------
// lbsm_checker: port-level checks for the LRU buffer slot manager
// Watches both item channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lbsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lbsm_pkg::out_item_t out_item
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed or dropped");

  // One item in flight: an accept closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // Failed requests carry no slot and no writeback
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != lbsm_pkg::STAT_OK) |->
      (out_item.slot == '0) && !out_item.writeback_valid)
    else $error("failed result carries slot or writeback");

  // Writeback block is zero unless a writeback is reported
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.writeback_valid |-> (out_item.writeback_block == '0))
    else $error("writeback block set without writeback");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind lru_buffer_slot_manager_unit lbsm_checker u_lbsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
